/* src/nearest_palette_color_search_assert.svh */
// Assertion macros for the nearest palette color search block.
// Depends on nothing; included by the top level.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define NPCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("npcs assertion failed");

// Consequence must hold in the cycle after the antecedent.
`define NPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("npcs assertion failed");

`endif

/* src/npcs_pkg.sv */
// Shared types and constants for the nearest palette color search block.
// No dependencies.
package npcs_pkg;

    localparam int COMP_W  = 6;
    localparam int FIELD_W = 5;
    localparam int DIST_W  = 14;   // 3 * 63 * 63 fits in 14 bits

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_PACKED = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    // Red sits in the high bits so a palette word reads red, green, blue.
    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } rgb_t;

endpackage

/* src/npcs_dist_unit.sv */
// Distance unit: squared Euclidean distance of one palette entry to the query.
// Depends on npcs_pkg. One registered stage, one entry per cycle.
module npcs_dist_unit #(
    parameter int IDX_W = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  logic [IDX_W-1:0]          in_idx,
    input  npcs_pkg::rgb_t            entry,
    input  npcs_pkg::rgb_t            query,
    output logic                      dist_valid,
    output logic [IDX_W-1:0]          dist_idx,
    output logic [npcs_pkg::DIST_W-1:0] dist_sum
);
    import npcs_pkg::*;

    logic [COMP_W-1:0]   d_red;
    logic [COMP_W-1:0]   d_green;
    logic [COMP_W-1:0]   d_blue;
    logic [2*COMP_W-1:0] sq_red;
    logic [2*COMP_W-1:0] sq_green;
    logic [2*COMP_W-1:0] sq_blue;
    logic [DIST_W-1:0]   dist_next;
    logic                dist_valid_reg;
    logic [IDX_W-1:0]    dist_idx_reg;
    logic [DIST_W-1:0]   dist_reg;

    always_comb begin
        d_red   = (query.red > entry.red) ? (query.red - entry.red)
                                          : (entry.red - query.red);
        d_green = (query.green > entry.green) ? (query.green - entry.green)
                                              : (entry.green - query.green);
        d_blue  = (query.blue > entry.blue) ? (query.blue - entry.blue)
                                            : (entry.blue - query.blue);
        sq_red   = d_red * d_red;
        sq_green = d_green * d_green;
        sq_blue  = d_blue * d_blue;
        dist_next = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_valid_reg <= 1'b0;
        end else begin
            dist_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        dist_idx_reg <= in_idx;
        dist_reg     <= dist_next;
    end

    assign dist_valid = dist_valid_reg;
    assign dist_idx   = dist_idx_reg;
    assign dist_sum   = dist_reg;

endmodule

/* src/nearest_palette_color_search.sv */
// Top level of the nearest palette color search block: palette memory and sequencer.
// Depends on npcs_pkg, npcs_dist_unit and nearest_palette_color_search_assert.svh.
//
// Usage:
//   The slave channel (s_tvalid, s_tready, s_tdata, s_tuser) carries requests.
//   s_tuser holds the request type: write a palette entry, query with three
//   6-bit components, or query with a packed 5:5:5 color whose fields are doubled.
//   A write gives no result. A query walks the palette
//   entries 0 to LIMIT-1, LIMIT being the smaller of SEARCH_ENTRIES and
//   PALETTE_ENTRIES, one memory read and one distance compare per cycle, and
//   returns the index of the nearest entry, the lowest index on equal distances.
//   The result appears on the master channel (m_tvalid, m_tready, m_tdata)
//   once the last entry has passed the memory read register, the distance
//   register and the compare; the next query is taken once the result has been
//   loaded into the output register. s_tready is low while a search runs.
//   A result waits in the output register while the receiver stalls; the block
//   meanwhile accepts the next request, and a finished search holds until the
//   output register is free.
//   Reset clears the control state only; the palette is undefined until written
//   and the searched entries must be written before the first query.
`include "nearest_palette_color_search_assert.svh"

module nearest_palette_color_search #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int SEARCH_ENTRIES  = 254
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata fields from bit 0: entry_index[7:0], red[13:8], green[19:14],
    // blue[25:20], packed_rgb[40:26], zero fill[47:41]
    input  logic [47:0] s_tdata,
    // s_tuser fields from bit 0: req_type[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata fields from bit 0: color_index[7:0]
    output logic [7:0]  m_tdata
);
    import npcs_pkg::*;

    localparam int AW    = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int LIMIT = (SEARCH_ENTRIES < PALETTE_ENTRIES) ? SEARCH_ENTRIES
                                                              : PALETTE_ENTRIES;
    localparam logic [AW-1:0] LAST_IDX = AW'(LIMIT - 1);

    rgb_t palette_mem [PALETTE_ENTRIES];

    state_t          state_reg, state_next;
    logic [AW-1:0]   addr_cnt_reg, addr_cnt_next;
    rgb_t            query_reg;
    rgb_t            query_next;
    rgb_t            rd_data_reg;
    logic [AW-1:0]   rd_idx_reg;
    logic            rd_valid_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [AW-1:0]   best_idx_reg;
    logic [AW-1:0]   res_idx_reg;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [7:0]      m_tdata_reg;

    req_type_t       req;
    logic            is_query;
    logic            wr_in_range;
    logic [31:0]     wr_wide;
    logic [AW-1:0]   wr_addr;
    rgb_t            wr_color;
    logic            issue;
    logic            load_query;
    logic            mem_we;
    logic            load_out;
    logic            out_free;

    logic              dist_valid;
    logic [AW-1:0]     dist_idx;
    logic [DIST_W-1:0] cur_dist;
    logic              take_new;
    logic              last_cmp;
    logic [AW-1:0]     final_idx;
    logic [31:0]       res_wide;

    // Request decode
    always_comb begin
        req         = req_type_t'(s_tuser);
        is_query    = req inside {REQ_QUERY, REQ_PACKED};
        wr_wide     = 32'(s_tdata[7:0]);
        wr_addr     = wr_wide[AW-1:0];
        wr_in_range = (wr_wide < 32'(PALETTE_ENTRIES));
        wr_color.red   = s_tdata[13:8];
        wr_color.green = s_tdata[19:14];
        wr_color.blue  = s_tdata[25:20];
        if (req == REQ_PACKED) begin
            query_next.red   = {s_tdata[40:36], 1'b0};
            query_next.green = {s_tdata[35:31], 1'b0};
            query_next.blue  = {s_tdata[30:26], 1'b0};
        end else begin
            query_next = wr_color;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // Compare stage: the first searched entry always loads the running best.
    always_comb begin
        take_new  = dist_valid && ((dist_idx == '0) || (cur_dist < best_dist_reg));
        last_cmp  = dist_valid && (dist_idx == LAST_IDX);
        final_idx = take_new ? dist_idx : best_idx_reg;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && is_query) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (addr_cnt_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (last_cmp) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready      = 1'b0;
        issue         = 1'b0;
        load_query    = 1'b0;
        mem_we        = 1'b0;
        load_out      = 1'b0;
        addr_cnt_next = addr_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                addr_cnt_next = '0;
                load_query    = s_tvalid && is_query;
                mem_we        = s_tvalid && (req == REQ_WRITE) && wr_in_range;
            end
            ST_SEARCH: begin
                issue         = 1'b1;
                addr_cnt_next = addr_cnt_reg + AW'(1);
            end
            ST_DRAIN: begin
            end
            ST_RESULT: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
        res_wide = 32'(res_idx_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            addr_cnt_reg <= '0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            addr_cnt_reg <= addr_cnt_next;
            rd_valid_reg <= issue;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            palette_mem[wr_addr] <= wr_color;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= palette_mem[addr_cnt_reg];
        rd_idx_reg  <= addr_cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (load_query) begin
            query_reg <= query_next;
        end
        if (take_new) begin
            best_dist_reg <= cur_dist;
            best_idx_reg  <= dist_idx;
        end
        if (state_reg == ST_DRAIN && last_cmp) begin
            res_idx_reg <= final_idx;
        end
        if (load_out) begin
            m_tdata_reg <= res_wide[7:0];
        end
    end

    npcs_dist_unit #(
        .IDX_W (AW)
    ) u_dist (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (rd_valid_reg),
        .in_idx     (rd_idx_reg),
        .entry      (rd_data_reg),
        .query      (query_reg),
        .dist_valid (dist_valid),
        .dist_idx   (dist_idx),
        .dist_sum   (cur_dist)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The read and distance pipeline only carries entries during a search.
    `NPCS_ASSERT_SAME(a_pipe_in_search, aclk, aresetn, dist_valid,
        (state_reg == ST_SEARCH) || (state_reg == ST_DRAIN))
    // An accepted query starts the palette walk in the next cycle.
    `NPCS_ASSERT_NEXT(a_query_starts, aclk, aresetn,
        s_tvalid && s_tready && ((req == REQ_QUERY) || (req == REQ_PACKED)),
        state_reg == ST_SEARCH)
    // A finished search never points past the searched range.
    `NPCS_ASSERT_SAME(a_result_in_range, aclk, aresetn, state_reg == ST_RESULT,
        res_idx_reg <= LAST_IDX)

endmodule
